@@ rtl/tpu_pkg.sv @@
// Shared types, constants and lookup functions for the tracker pattern unpacker.
`timescale 1ns / 1ps

package tpu_pkg;

  // Widths fixed by the stream format
  localparam int ROW_CNT_W  = 7;
  localparam int MASK_W     = 32;
  localparam int ROWS_DEF   = 64;
  localparam int SRC_CH_DEF = 32;

  // Queue between the parser and the converter
  localparam int QUEUE_DEPTH = 4;

  // Parser phases
  localparam logic [2:0] PH_LEN_LO = 3'd0;
  localparam logic [2:0] PH_LEN_HI = 3'd1;
  localparam logic [2:0] PH_FLAG   = 3'd2;
  localparam logic [2:0] PH_NOTE   = 3'd3;
  localparam logic [2:0] PH_INST   = 3'd4;
  localparam logic [2:0] PH_VOL    = 3'd5;
  localparam logic [2:0] PH_CMD    = 3'd6;
  localparam logic [2:0] PH_INFO   = 3'd7;

  // Special byte codes
  localparam logic [7:0] NOTE_EMPTY     = 8'hff;
  localparam logic [7:0] NOTE_STOP      = 8'hfe;
  localparam logic [7:0] TEMPO_MIN_INFO = 8'h20;
  localparam logic [7:0] VOL_SAT_IN     = 8'd64;
  localparam logic [7:0] VOL_MAX        = 8'hff;

  // Command codes
  localparam logic [4:0] CMD_NONE  = 5'd0;
  localparam logic [4:0] CMD_TEMPO = 5'd17;
  localparam logic [4:0] CMD_OTHER = 5'd19;

  // One decoded entry, raw bytes, handed from parser to converter
  typedef struct packed {
    logic       done;
    logic       with_cell;
    logic [5:0] row;
    logic [4:0] src;
    logic       note_present;
    logic [7:0] note_raw;
    logic [7:0] inst;
    logic       has_vol;
    logic [7:0] vol_raw;
    logic       has_cmd;
    logic [7:0] effect;
    logic [7:0] info;
  } tpu_rec_t;

  // Map an effect letter code to the renumbered command
  function automatic logic [4:0] map_command(input logic [7:0] cmd, input logic [7:0] info);
    logic [4:0] c;
    begin
      case (cmd)
        8'd1:  c = 5'd1;
        8'd2:  c = 5'd2;
        8'd3:  c = 5'd3;
        8'd4:  c = 5'd4;
        8'd5:  c = 5'd5;
        8'd6:  c = 5'd6;
        8'd7:  c = 5'd7;
        8'd8:  c = 5'd8;
        8'd9:  c = 5'd9;
        8'd10: c = 5'd10;
        8'd11: c = 5'd11;
        8'd12: c = 5'd12;
        8'd15: c = 5'd13;
        8'd17: c = 5'd14;
        8'd18: c = 5'd15;
        8'd19: c = 5'd16;
        8'd20: c = CMD_TEMPO;
        8'd22: c = 5'd18;
        default: c = CMD_OTHER;
      endcase
      // tempo values at or below the threshold are not real tempos
      if (c == CMD_TEMPO && info <= TEMPO_MIN_INFO) c = CMD_OTHER;
      return c;
    end
  endfunction

endpackage

@@ rtl/tpu_front.sv @@
// Byte parser: walks the packed stream, queues a record per entry with a cell or at pattern end.
`timescale 1ns / 1ps

module tpu_front import tpu_pkg::*; #(
  parameter int ROWS = ROWS_DEF
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              take,
  input  logic [7:0]        data_byte,
  input  logic              pattern_start,
  input  logic [MASK_W-1:0] eff_mask,
  output logic              push,
  output tpu_rec_t          rec
);

  logic [2:0]           phase, phase_next;
  logic [ROW_CNT_W-1:0] row_count, row_count_next;
  logic [15:0]          bytes_left, bytes_left_next, bl_dec;
  logic [7:0]           length_low, length_low_next;
  logic [2:0]           pending, pending_next;
  logic                 used, used_next;
  logic [4:0]           src, src_next;
  logic [7:0]           note_raw, note_raw_next;
  logic [7:0]           inst, inst_next;
  logic [7:0]           vol_raw, vol_raw_next;
  logic [7:0]           effect, effect_next;
  logic [7:0]           info_v;
  logic                 complete;
  logic                 cell_out;
  logic                 done;
  logic                 row_open;

  // Phase after the flag (stage 0), instrument (1) or volume (2)
  function automatic logic [2:0] next_ph(input logic [2:0] p, input logic [1:0] stage);
    logic [2:0] n;
    begin
      if (stage == 2'd0 && p[0]) n = PH_NOTE;
      else if (stage <= 2'd1 && p[1]) n = PH_VOL;
      else if (p[2]) n = PH_CMD;
      else n = PH_FLAG;
      return n;
    end
  endfunction

  assign bl_dec   = bytes_left - {15'd0, (bytes_left != 16'd0)};
  assign row_open = row_count < ROW_CNT_W'(ROWS);

  always_comb begin
    phase_next      = phase;
    row_count_next  = row_count;
    bytes_left_next = bytes_left;
    length_low_next = length_low;
    pending_next    = pending;
    used_next       = used;
    src_next        = src;
    note_raw_next   = note_raw;
    inst_next       = inst;
    vol_raw_next    = vol_raw;
    effect_next     = effect;
    info_v          = 8'd0;
    complete        = 1'b0;
    cell_out        = 1'b0;
    done            = 1'b0;
    push            = 1'b0;
    if (take) begin
      if (pattern_start || phase == PH_LEN_LO) begin
        // new pattern: drop any partial entry
        length_low_next = data_byte;
        row_count_next  = '0;
        pending_next    = 3'd0;
        used_next       = 1'b0;
        phase_next      = PH_LEN_HI;
      end else if (phase == PH_LEN_HI) begin
        bytes_left_next = {data_byte, length_low};
        phase_next      = PH_FLAG;
        if ({data_byte, length_low} == 16'd0) begin
          done = 1'b1;
          push = 1'b1;
        end
      end else if (!(phase == PH_FLAG && bytes_left == 16'd0)) begin
        bytes_left_next = bl_dec;
        case (phase)
          PH_FLAG: begin
            if (data_byte == 8'd0) begin
              if (row_open) row_count_next = row_count + 1'b1;
              used_next = 1'b0;
              complete  = 1'b1;
            end else begin
              pending_next  = data_byte[7:5];
              src_next      = data_byte[4:0];
              used_next     = eff_mask[data_byte[4:0]] && row_open;
              note_raw_next = 8'd0;
              inst_next     = 8'd0;
              vol_raw_next  = 8'd0;
              effect_next   = 8'd0;
              phase_next    = next_ph(data_byte[7:5], 2'd0);
              complete      = (phase_next == PH_FLAG);
            end
          end
          PH_NOTE: begin
            note_raw_next = data_byte;
            phase_next    = PH_INST;
          end
          PH_INST: begin
            inst_next  = data_byte;
            phase_next = next_ph(pending, 2'd1);
            complete   = (phase_next == PH_FLAG);
          end
          PH_VOL: begin
            vol_raw_next = data_byte;
            phase_next   = next_ph(pending, 2'd2);
            complete     = (phase_next == PH_FLAG);
          end
          PH_CMD: begin
            effect_next = data_byte;
            phase_next  = PH_INFO;
          end
          default: begin
            info_v     = data_byte;
            phase_next = PH_FLAG;
            complete   = 1'b1;
          end
        endcase
        if (complete) begin
          cell_out  = used_next;
          done      = (bl_dec == 16'd0);
          used_next = 1'b0;
          push      = cell_out || done;
        end
      end
    end
  end

  always_comb begin
    rec.done         = done;
    rec.with_cell    = cell_out;
    rec.row          = row_count_next[5:0];
    rec.src          = src_next;
    rec.note_present = pending_next[0];
    rec.note_raw     = note_raw_next;
    rec.inst         = inst_next;
    rec.has_vol      = pending_next[1];
    rec.vol_raw      = vol_raw_next;
    rec.has_cmd      = pending_next[2];
    rec.effect       = effect_next;
    rec.info         = info_v;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase      <= PH_LEN_LO;
      row_count  <= '0;
      bytes_left <= 16'd0;
      pending    <= 3'd0;
      used       <= 1'b0;
    end else begin
      phase      <= phase_next;
      row_count  <= row_count_next;
      bytes_left <= bytes_left_next;
      pending    <= pending_next;
      used       <= used_next;
    end
  end

  always_ff @(posedge clk) begin
    length_low <= length_low_next;
    src        <= src_next;
    note_raw   <= note_raw_next;
    inst       <= inst_next;
    vol_raw    <= vol_raw_next;
    effect     <= effect_next;
  end

endmodule

@@ rtl/tpu_fifo.sv @@
// Short record queue between the parser and the converter.
`timescale 1ns / 1ps

module tpu_fifo import tpu_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  logic     push,
  input  tpu_rec_t push_rec,
  input  logic     pop,
  output tpu_rec_t pop_rec,
  output logic     empty,
  output logic     full
);

  localparam int PTR_W = $clog2(QUEUE_DEPTH);
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

  tpu_rec_t         slots [QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;
  logic             do_push;
  logic             do_pop;

  assign empty   = (count == CNT_W'(0));
  assign full    = (count == CNT_W'(QUEUE_DEPTH));
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign pop_rec = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) wr_ptr <= (wr_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      if (do_pop)  rd_ptr <= (rd_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      case ({do_push, do_pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) slots[wr_ptr] <= push_rec;
  end

endmodule

@@ rtl/tpu_back.sv @@
// Converter: turns queued raw entries into result words in an output register.
`timescale 1ns / 1ps

module tpu_back import tpu_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  tpu_rec_t          rec,
  input  logic              rec_avail,
  output logic              pop,
  input  logic [MASK_W-1:0] eff_mask,
  input  logic [6:0]        note_floor,
  input  logic [6:0]        note_ceil,
  input  logic [7:0]        pattern_number,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [7:0]        pattern_index,
  output logic [5:0]        row,
  output logic [4:0]        channel,
  output logic [6:0]        note,
  output logic              stop_flag,
  output logic [7:0]        instrument,
  output logic              vol_present,
  output logic [7:0]        volume,
  output logic [4:0]        command,
  output logic [7:0]        info,
  output logic              cell_valid,
  output logic              pattern_done
);

  logic [MASK_W-1:0] below;
  logic [4:0]        ch_c;
  logic [7:0]        semi_sum;
  logic [6:0]        note_c;
  logic [7:0]        vol_c;
  logic [4:0]        cmd_c;

  assign pop = rec_avail && (!out_valid || out_ready);

  // enabled channels below the source channel
  assign below = eff_mask & ~({MASK_W{1'b1}} << rec.src);
  assign ch_c  = 5'($countones(below));

  // octave*12 + semitone + 12, then clamp
  assign semi_sum = ({4'd0, rec.note_raw[7:4]} * 8'd12) + {4'd0, rec.note_raw[3:0]} + 8'd12;

  always_comb begin
    if (semi_sum < {1'b0, note_floor}) note_c = note_floor;
    else if (semi_sum > {1'b0, note_ceil}) note_c = note_ceil;
    else note_c = semi_sum[6:0];
    if (!rec.note_present || rec.note_raw == NOTE_EMPTY || rec.note_raw == NOTE_STOP) begin
      note_c = 7'd0;
    end
  end

  always_comb begin
    if (rec.vol_raw == 8'd0) vol_c = 8'd0;
    else if (rec.vol_raw >= VOL_SAT_IN) vol_c = VOL_MAX;
    else vol_c = {rec.vol_raw[5:0], 2'b00} - 8'd1;
  end

  assign cmd_c = rec.has_cmd ? map_command(rec.effect, rec.info) : CMD_NONE;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (pop) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      pattern_index <= pattern_number;
      pattern_done  <= rec.done;
      cell_valid    <= rec.with_cell;
      if (rec.with_cell) begin
        row         <= rec.row;
        channel     <= ch_c;
        note        <= note_c;
        stop_flag   <= rec.note_present && (rec.note_raw == NOTE_STOP);
        instrument  <= rec.inst;
        vol_present <= rec.has_vol;
        volume      <= rec.has_vol ? vol_c : 8'd0;
        command     <= cmd_c;
        info        <= rec.has_cmd ? rec.info : 8'd0;
      end else begin
        row         <= 6'd0;
        channel     <= 5'd0;
        note        <= 7'd0;
        stop_flag   <= 1'b0;
        instrument  <= 8'd0;
        vol_present <= 1'b0;
        volume      <= 8'd0;
        command     <= CMD_NONE;
        info        <= 8'd0;
      end
    end
  end

endmodule

@@ rtl/tracker_pattern_unpacker_top.sv @@
// Top level of the tracker pattern unpacker: register port, parser, queue, converter.
`timescale 1ns / 1ps

// Packed pattern bytes enter on the slave stream, one byte per word, and are
// taken at one word per clock while the queue has room, with no gap between
// patterns. The first length byte of a pattern is marked by s_tuser. Each
// finished entry on an enabled channel within the first ROWS rows leaves as
// one result word on the master stream; m_tuser is high when the word carries
// a cell and m_tlast is high on the word that ends the declared pattern length
// (it may carry a cell too, or stand alone with all cell fields zero). Bytes
// after the end are dropped until the next s_tuser. On the way from the
// accepted byte that finishes an entry to its result on the master side, the
// parser writes the entry into a four-word queue, and the converter (channel
// compaction, note clamp, volume scale, command map) loads the output
// register. The queue lets the input keep moving while the output stalls,
// until four entries wait; s_tready drops only when the queue is full. Write
// the registers over the APB port only while no pattern is in flight.

module tracker_pattern_unpacker_top import tpu_pkg::*; #(
  parameter int ROWS            = ROWS_DEF,
  parameter int SOURCE_CHANNELS = SRC_CH_DEF
) (
  input  logic        clk,
  input  logic        rst,
  // slave stream
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,   // [7:0] data_byte
  input  logic        s_tuser,   // [0] pattern_start
  // master stream
  output logic        m_tvalid,
  input  logic        m_tready,
  // [7:0] pattern_index, [13:8] row, [18:14] channel, [25:19] note,
  // [26] stop flag, [34:27] instrument, [35] volume present, [43:36] volume,
  // [48:44] command, [56:49] info, [63:57] zero
  output logic [63:0] m_tdata,
  output logic        m_tuser,   // [0] cell_valid
  output logic        m_tlast,   // pattern_done
  // register port
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  // Register map, word index
  localparam logic [1:0] REG_MASK    = 2'd0;
  localparam logic [1:0] REG_LOWEST  = 2'd1;
  localparam logic [1:0] REG_HIGHEST = 2'd2;
  localparam logic [1:0] REG_PATTERN = 2'd3;

  // Channels at or above SOURCE_CHANNELS never take a cell
  localparam logic [63:0]       SC_FULL = (64'd1 << SOURCE_CHANNELS) - 64'd1;
  localparam logic [MASK_W-1:0] SC_MASK = SC_FULL[MASK_W-1:0];

  logic [MASK_W-1:0] channel_enable_mask;
  logic [6:0]        note_floor;
  logic [6:0]        note_ceil;
  logic [7:0]        pattern_number;
  logic [MASK_W-1:0] eff_mask;
  logic              wr_en;

  logic              take;
  logic              push;
  tpu_rec_t          push_rec;
  tpu_rec_t          pop_rec;
  logic              pop;
  logic              q_empty;
  logic              q_full;

  logic [7:0]        pattern_index;
  logic [5:0]        row;
  logic [4:0]        channel;
  logic [6:0]        note;
  logic              stop_flag;
  logic [7:0]        instrument;
  logic              vol_present;
  logic [7:0]        volume;
  logic [4:0]        command;
  logic [7:0]        info;

  // Register port: zero wait states
  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      channel_enable_mask <= 32'h0000ffff;
      note_floor          <= 7'd12;
      note_ceil           <= 7'd107;
      pattern_number      <= 8'd0;
    end else if (wr_en) begin
      case (paddr[3:2])
        REG_MASK:    channel_enable_mask <= pwdata;
        REG_LOWEST:  note_floor          <= pwdata[6:0];
        REG_HIGHEST: note_ceil           <= pwdata[6:0];
        REG_PATTERN: pattern_number      <= pwdata[7:0];
        default:     channel_enable_mask <= channel_enable_mask;
      endcase
    end
  end

  always_comb begin
    case (paddr[3:2])
      REG_MASK:    prdata = channel_enable_mask;
      REG_LOWEST:  prdata = {25'd0, note_floor};
      REG_HIGHEST: prdata = {25'd0, note_ceil};
      REG_PATTERN: prdata = {24'd0, pattern_number};
      default:     prdata = 32'd0;
    endcase
  end

  assign eff_mask = channel_enable_mask & SC_MASK;

  // Input side: hold off only when the queue cannot take another entry
  assign s_tready = !q_full;
  assign take     = s_tvalid && s_tready;

  tpu_front #(
    .ROWS (ROWS)
  ) u_front (
    .clk           (clk),
    .rst           (rst),
    .take          (take),
    .data_byte     (s_tdata),
    .pattern_start (s_tuser),
    .eff_mask      (eff_mask),
    .push          (push),
    .rec           (push_rec)
  );

  tpu_fifo u_fifo (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_rec (push_rec),
    .pop      (pop),
    .pop_rec  (pop_rec),
    .empty    (q_empty),
    .full     (q_full)
  );

  tpu_back u_back (
    .clk            (clk),
    .rst            (rst),
    .rec            (pop_rec),
    .rec_avail      (!q_empty),
    .pop            (pop),
    .eff_mask       (eff_mask),
    .note_floor     (note_floor),
    .note_ceil      (note_ceil),
    .pattern_number (pattern_number),
    .out_valid      (m_tvalid),
    .out_ready      (m_tready),
    .pattern_index  (pattern_index),
    .row            (row),
    .channel        (channel),
    .note           (note),
    .stop_flag      (stop_flag),
    .instrument     (instrument),
    .vol_present    (vol_present),
    .volume         (volume),
    .command        (command),
    .info           (info),
    .cell_valid     (m_tuser),
    .pattern_done   (m_tlast)
  );

  // Pack the result word, first field lowest
  assign m_tdata = {7'd0, info, command, volume, vol_present, instrument,
                    stop_flag, note, channel, row, pattern_index};

endmodule
